// ----- rtl/cow_rct_pkg.sv -----
// ----------------------------------------------------------------------------
// cow_rct_pkg: shared types and constants
// Sizes of the entry pool and the bucket table, operation and status codes,
// and the command and status structs that pass between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package cow_rct_pkg;
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned Buckets = 1024;
  localparam int unsigned PageShift = 12;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned LinkW = IdxW + 1;
  localparam int unsigned BktW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned StepW = IdxW + 1;
  localparam logic [LinkW-1:0] LinkNone = LinkW'(TableEntries);
  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_SHARE   = 2'd0,
    MODE_FAULT   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_COPIED  = 2'd1,
    ST_NOMEM   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_READ,
    S_CHECK,
    S_ACT,
    S_FREE,
    S_DONE
  } state_t;

  // Controller commands toward the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic head_rd;
    logic ent_rd;
    logic walk_adv;
    logic take;
    logic act;
    logic do_free;
    logic done;
  } cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic clear_last;
    logic chain_end;
    logic hit;
    logic need_unlink;
  } stat_t;

  function automatic logic [BktW-1:0] bucket_of(input logic [31:0] addr);
    logic [31:0] pn;
    begin
      pn = addr >> PageShift;
      bucket_of = BktW'(pn % Buckets);
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/cow_page_refcount_table_core.sv -----
// ----------------------------------------------------------------------------
// cow_page_refcount_table_core: copy-on-write page reference count table
// Hashed chains of page entries with counts over a pool with a free list.
// ----------------------------------------------------------------------------
// Sequence: head read, then a read and a check per chain link, then the update, and
// a free step when an entry drops out; done is registered from the done state.
// Throughput: one operation at a time; a new word is taken in the done cycle.
// Reset: synchronous; the bucket heads are then cleared one per cycle, and busy
// stays high until the last is cleared. The receiver cannot stall the result word.
`default_nettype none
module cow_page_refcount_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] page_address,
  input  wire logic [31:0] copy_frame,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      result_address,
  output logic [15:0]      reference_count,
  output logic             free_frame,
  output logic [31:0]      shared_total,
  output logic [31:0]      copied_total
);
  import cow_rct_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  ctrl_busy;

  cow_rct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .cmd(cmd), .busy(ctrl_busy)
  );

  cow_rct_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .mode(mode), .page_address(page_address),
    .copy_frame(copy_frame), .st(st), .done(done), .status(status),
    .result_address(result_address), .reference_count(reference_count),
    .free_frame(free_frame), .shared_total(shared_total),
    .copied_total(copied_total)
  );

  assign busy = ctrl_busy;
endmodule
`default_nettype wire

// ----- rtl/cow_rct_ctrl.sv -----
// ----------------------------------------------------------------------------
// cow_rct_ctrl: operation sequencer
// Clears the bucket heads after reset, then steps through head read, chain
// walk, update and the optional return of an entry to the free list.
// ----------------------------------------------------------------------------
`default_nettype none
module cow_rct_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  cow_rct_pkg::stat_t     st,
  output cow_rct_pkg::cmd_t      cmd,
  output logic                   busy
);
  import cow_rct_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (st.clear_last) state_next = S_IDLE;
      S_IDLE:    if (start) state_next = S_HEAD;
      S_HEAD:    state_next = S_READ;
      S_READ:    state_next = st.chain_end ? S_ACT : S_CHECK;
      S_CHECK:   state_next = st.hit ? S_ACT : S_READ;
      S_ACT:     state_next = st.need_unlink ? S_FREE : S_DONE;
      S_FREE:    state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_CLEAR:   cmd.clear = 1'b1;
      S_IDLE:    cmd.load = start;
      S_HEAD:    cmd.head_rd = 1'b1;
      S_READ:    cmd.ent_rd = !st.chain_end;
      S_CHECK: begin
        cmd.take = st.hit;
        cmd.walk_adv = !st.hit;
      end
      S_ACT:     cmd.act = 1'b1;
      S_FREE:    cmd.do_free = 1'b1;
      S_DONE:    cmd.done = 1'b1;
      default:   cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/cow_rct_dp.sv -----
// ----------------------------------------------------------------------------
// cow_rct_dp: table datapath
// Holds the entry memories, bucket heads, free list and totals.
// ----------------------------------------------------------------------------
`default_nettype none
module cow_rct_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  cow_rct_pkg::cmd_t      cmd,
  input  wire logic [1:0]        mode,
  input  wire logic [31:0]       page_address,
  input  wire logic [31:0]       copy_frame,
  output cow_rct_pkg::stat_t     st,
  output logic                   done,
  output logic [1:0]             status,
  output logic [31:0]            result_address,
  output logic [15:0]            reference_count,
  output logic                   free_frame,
  output logic [31:0]            shared_total,
  output logic [31:0]            copied_total
);
  import cow_rct_pkg::*;

  logic [31:0]      ent_addr_mem [TableEntries];
  logic [15:0]      ent_cnt_mem  [TableEntries];
  logic [LinkW-1:0] ent_next_mem [TableEntries];
  logic [LinkW-1:0] head_mem     [Buckets];

  logic [1:0]       op_mode;
  logic [31:0]      op_addr;
  logic [31:0]      op_frame;
  logic [BktW-1:0]  op_bkt;
  logic [LinkW-1:0] head_q;
  logic [LinkW-1:0] cur;
  logic [LinkW-1:0] prev;
  logic [StepW-1:0] steps;
  logic [31:0]      rd_addr;
  logic [15:0]      rd_cnt;
  logic [LinkW-1:0] rd_next;
  logic [LinkW-1:0] free_next;
  logic [LinkW-1:0] found;
  logic [LinkW-1:0] found_prev;
  logic [LinkW-1:0] found_next;
  logic [15:0]      found_cnt;
  logic [LinkW-1:0] free_head;
  logic [LinkW-1:0] unused_index;
  logic [BktW-1:0]  clr_idx;
  logic [31:0]      shared_counter;
  logic [31:0]      copied_counter;
  logic             out_v;
  logic [1:0]       o_status;
  logic [31:0]      o_result;
  logic [15:0]      o_count;
  logic             o_free;

  logic             found_ok;
  logic [15:0]      cnt_up;
  logic [15:0]      cnt_down;
  logic [LinkW-1:0] new_e;
  logic             new_ok;
  logic             need_c;
  logic [1:0]       act_status;
  logic [31:0]      act_result;
  logic [15:0]      act_count;
  logic             act_free;
  logic             add_shared;
  logic             add_copied;
  logic             addr_we;
  logic             cnt_we;
  logic [IdxW-1:0]  cnt_wa;
  logic [15:0]      cnt_wd;
  logic             head_we;
  logic [BktW-1:0]  head_wa;
  logic [LinkW-1:0] head_wd;
  logic             next_we;
  logic [IdxW-1:0]  next_wa;
  logic [LinkW-1:0] next_wd;

  assign found_ok = (found < LinkNone);
  assign cnt_up = (found_cnt < CountMax) ? found_cnt + 16'd1 : found_cnt;
  assign cnt_down = (found_cnt > 16'd0) ? found_cnt - 16'd1 : 16'd0;
  assign new_ok = (free_head < LinkNone) || (unused_index < LinkNone);
  assign new_e = (free_head < LinkNone) ? free_head : unused_index;

  // A copy that leaves one reference, or a release to zero, drops the entry.
  assign need_c = found_ok &&
                  ((op_mode == MODE_FAULT && found_cnt == 16'd2 && op_frame != 32'd0) ||
                   (op_mode == MODE_RELEASE && found_cnt <= 16'd1));

  always_comb begin
    st.clear_last = (clr_idx == BktW'(Buckets - 1));
    st.chain_end = (cur >= LinkNone) || (steps >= StepW'(TableEntries));
    st.hit = (rd_addr == op_addr);
    st.need_unlink = need_c;
  end

  // Result and count update for the looked-up entry.
  always_comb begin
    act_status = ST_OK;
    act_result = op_addr;
    act_count = 16'd1;
    act_free = 1'b0;
    add_shared = 1'b0;
    add_copied = 1'b0;
    addr_we = 1'b0;
    cnt_we = 1'b0;
    cnt_wa = found[IdxW-1:0];
    cnt_wd = cnt_down;
    case (op_mode)
      MODE_SHARE: begin
        if (found_ok) begin
          act_count = cnt_up;
          cnt_we = 1'b1;
          cnt_wd = cnt_up;
          add_shared = 1'b1;
        end else if (new_ok) begin
          addr_we = 1'b1;
          cnt_we = 1'b1;
          cnt_wa = new_e[IdxW-1:0];
          cnt_wd = 16'd2;
          act_count = 16'd2;
          add_shared = 1'b1;
        end else begin
          act_status = ST_NOMEM;
        end
      end
      MODE_FAULT: begin
        if (found_ok) begin
          act_count = found_cnt;
          if (found_cnt > 16'd1) begin
            if (op_frame == 32'd0) begin
              act_status = ST_NOMEM;
            end else begin
              cnt_we = 1'b1;
              act_count = cnt_down;
              add_copied = 1'b1;
              act_status = ST_COPIED;
              act_result = op_frame;
            end
          end
        end
      end
      MODE_RELEASE: begin
        if (found_ok) begin
          cnt_we = 1'b1;
          act_count = cnt_down;
          act_free = (found_cnt <= 16'd1);
        end
      end
      default: begin
        if (found_ok) act_count = found_cnt;
      end
    endcase
  end

  // Write ports of the head and link memories.
  always_comb begin
    head_we = 1'b0;
    head_wa = op_bkt;
    head_wd = LinkNone;
    next_we = 1'b0;
    next_wa = new_e[IdxW-1:0];
    next_wd = head_q;
    if (cmd.clear) begin
      head_we = 1'b1;
      head_wa = clr_idx;
    end
    if (cmd.act && addr_we) begin
      head_we = 1'b1;
      head_wd = new_e;
      next_we = 1'b1;
    end
    if (cmd.act && need_c) begin
      if (found_prev >= LinkNone) begin
        head_we = 1'b1;
        head_wd = found_next;
      end else begin
        next_we = 1'b1;
        next_wa = found_prev[IdxW-1:0];
        next_wd = found_next;
      end
    end
    if (cmd.do_free) begin
      next_we = 1'b1;
      next_wa = found[IdxW-1:0];
      next_wd = free_head;
    end
  end

  // Memories and the chain walk; every read is registered.
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (next_we) ent_next_mem[next_wa] <= next_wd;
    if (cmd.act && addr_we) ent_addr_mem[new_e[IdxW-1:0]] <= op_addr;
    if (cmd.act && cnt_we) ent_cnt_mem[cnt_wa] <= cnt_wd;
    if (cmd.head_rd) begin
      head_q <= head_mem[op_bkt];
      cur <= head_mem[op_bkt];
      prev <= LinkNone;
      steps <= '0;
      free_next <= ent_next_mem[free_head[IdxW-1:0]];
    end
    if (cmd.ent_rd) begin
      rd_addr <= ent_addr_mem[cur[IdxW-1:0]];
      rd_cnt  <= ent_cnt_mem[cur[IdxW-1:0]];
      rd_next <= ent_next_mem[cur[IdxW-1:0]];
    end
    if (cmd.walk_adv) begin
      prev <= cur;
      cur <= rd_next;
      steps <= steps + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= LinkNone;
      unused_index <= '0;
      clr_idx <= '0;
      shared_counter <= '0;
      copied_counter <= '0;
      out_v <= 1'b0;
      found <= LinkNone;
      o_status <= ST_OK;
      o_result <= '0;
      o_count <= '0;
      o_free <= 1'b0;
    end else begin
      out_v <= cmd.done;
      if (cmd.clear) clr_idx <= clr_idx + 1'b1;
      if (cmd.load) begin
        op_mode <= mode;
        op_addr <= page_address;
        op_frame <= copy_frame;
        op_bkt <= bucket_of(page_address);
        found <= LinkNone;
      end
      if (cmd.take) begin
        found <= cur;
        found_prev <= prev;
        found_next <= rd_next;
        found_cnt <= rd_cnt;
      end
      if (cmd.act) begin
        o_status <= act_status;
        o_result <= act_result;
        o_count <= act_count;
        o_free <= act_free;
        if (add_shared) shared_counter <= shared_counter + 32'd1;
        if (add_copied) copied_counter <= copied_counter + 32'd1;
        if (addr_we) begin
          if (free_head < LinkNone) free_head <= free_next;
          else unused_index <= unused_index + 1'b1;
        end
      end
      if (cmd.do_free) free_head <= found;
    end
  end

  assign done = out_v;
  assign status = o_status;
  assign result_address = o_result;
  assign reference_count = o_count;
  assign free_frame = o_free;
  assign shared_total = shared_counter;
  assign copied_total = copied_counter;
endmodule
`default_nettype wire
